// ----- rtl/ptd_pkg.sv -----
// Shared types and codes for the priority task dispatcher.
package ptd_pkg;

  localparam int ID_W   = 6;
  localparam int TIME_W = 32;

  typedef enum logic [1:0] {
    OP_ADD      = 2'd0,
    OP_DISPATCH = 2'd1,
    OP_COMPLETE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_NONE  = 2'd2,
    STAT_BAD   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SLOT_INACTIVE = 2'd0,
    SLOT_READY    = 2'd1,
    SLOT_RUNNING  = 2'd2,
    SLOT_BLOCKED  = 2'd3
  } slot_state_t;

  typedef struct packed {
    logic [1:0]        operation;
    logic [1:0]        priority_req;
    logic [TIME_W-1:0] now_ms;
    logic [TIME_W-1:0] delay_ms;
    logic              delays;
  } cmd_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ID_W-1:0]   task_id;
    logic [TIME_W-1:0] uptime_ms;
  } result_t;

endpackage

// ----- rtl/ptd_table.sv -----
// Task table memory: one write port, one registered read port, write-to-read bypass.
module ptd_table #(
  parameter int DEPTH  = 8,
  parameter int DATA_W = 68,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [AW-1:0]     rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_q;
  logic [AW-1:0]     rd_addr_q;
  logic              fwd_valid;
  logic [AW-1:0]     fwd_addr;
  logic [DATA_W-1:0] fwd_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q      <= mem[rd_addr];
    rd_addr_q <= rd_addr;
    fwd_addr  <= wr_addr;
    fwd_data  <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= wr_en;
    end
  end

  // a read taken on the same edge as a write to that entry sees old data: bypass it
  assign rd_data = (fwd_valid && (fwd_addr == rd_addr_q)) ? fwd_data : rd_q;

endmodule

// ----- rtl/priority_task_dispatcher.sv -----
// Add, complete and unknown commands are taken with busy staying low, and their result
// strobes on done in the next cycle, so such commands can follow back to back. A dispatch
// raises busy and reads the task table once per cycle, one cursor position at a time; busy
// stays high until a grant at the j-th position visited (1 up to TASK_SLOTS*PRIORITY_LEVELS)
// or the last position without one, and done strobes in the cycle that follows. The result
// must be taken in its done cycle; result holds it only until the next command. No table
// clearing pass runs after reset: entries at or above the fill count read as inactive.
module priority_task_dispatcher #(
  parameter int TASK_SLOTS      = 8,
  parameter int PRIORITY_LEVELS = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  ptd_pkg::cmd_t    cmd,
  output logic             done,
  output ptd_pkg::result_t result
);

  import ptd_pkg::*;

  localparam int SW        = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CW        = $clog2(TASK_SLOTS + 1);
  localparam int PW        = $clog2(PRIORITY_LEVELS);
  localparam int POSITIONS = TASK_SLOTS * PRIORITY_LEVELS;
  localparam int NCW       = $clog2(POSITIONS);

  localparam logic [SW-1:0]  LAST_SLOT = SW'(TASK_SLOTS - 1);
  localparam logic [PW-1:0]  TOP_PRIO  = PW'(PRIORITY_LEVELS - 1);
  localparam logic [NCW-1:0] LAST_POS  = NCW'(POSITIONS - 1);
  localparam logic [CW-1:0]  FULL_CNT  = CW'(TASK_SLOTS);

  typedef struct packed {
    slot_state_t       st;
    logic [PW-1:0]     prio;
    logic [TIME_W-1:0] wake;
    logic [TIME_W-1:0] runs;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_SWEEP = 2'b10
  } fsm_t;

  fsm_t              state, state_next;
  logic [SW-1:0]     cur_s, cur_s_next, iss_s, iss_s_next, run_slot, run_slot_next;
  logic [PW-1:0]     cur_p, cur_p_next;
  logic [CW-1:0]     fill, fill_next;
  logic [NCW-1:0]    cnt, cnt_next;
  logic              run_valid, run_valid_next;
  rec_t              run_rec, run_rec_next;
  logic [TIME_W-1:0] uptime, uptime_next, last_time, last_time_next, now_q, now_q_next;
  logic              done_next;
  result_t           result_next;

  logic              wr_en;
  logic [SW-1:0]     wr_addr, rd_addr;
  rec_t              wr_data, rec;
  logic [REC_W-1:0]  rd_raw;

  logic [SW-1:0]     cur_s_inc, iss_s_inc;
  logic [PW-1:0]     cur_p_dec, pri_sat;
  logic [TIME_W-1:0] elapsed;
  logic              active, expired, blocked, grant, wake_wr, at_top;

  ptd_table #(
    .DEPTH  (TASK_SLOTS),
    .DATA_W (REC_W)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_raw)
  );

  assign rec       = rec_t'(rd_raw);
  assign cur_s_inc = (cur_s == LAST_SLOT) ? '0 : cur_s + SW'(1);
  assign iss_s_inc = (iss_s == LAST_SLOT) ? '0 : iss_s + SW'(1);
  assign cur_p_dec = (cur_p == '0) ? TOP_PRIO : cur_p - PW'(1);
  assign pri_sat   = ({2'b00, cmd.priority_req} >= 4'(PRIORITY_LEVELS)) ? TOP_PRIO
                                                                       : PW'(cmd.priority_req);

  // evaluation of the cursor position whose table entry has just been read
  assign active  = (CW'(cur_s) < fill);
  assign elapsed = now_q - rec.wake;
  assign expired = ~elapsed[TIME_W-1];
  assign blocked = (rec.st == SLOT_BLOCKED);
  assign wake_wr = active && blocked && expired;
  assign grant   = active && ((rec.st == SLOT_READY) || wake_wr) && (rec.prio == cur_p);
  assign at_top  = (cur_p == TOP_PRIO) && (cur_s == '0);

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next     = state;
    cur_s_next     = cur_s;
    cur_p_next     = cur_p;
    iss_s_next     = iss_s;
    run_slot_next  = run_slot;
    run_valid_next = run_valid;
    run_rec_next   = run_rec;
    fill_next      = fill;
    cnt_next       = cnt;
    uptime_next    = uptime;
    last_time_next = last_time;
    now_q_next     = now_q;
    done_next      = 1'b0;
    result_next    = result;
    wr_en          = 1'b0;
    wr_addr        = run_slot;
    wr_data        = run_rec;
    rd_addr        = iss_s;

    case (state)
      S_IDLE: begin
        rd_addr = cur_s;
        if (start) begin
          done_next           = 1'b1;
          result_next.status  = STAT_OK;
          result_next.task_id = '0;
          case (cmd.operation)
            OP_ADD: begin
              if (fill < FULL_CNT) begin
                wr_en               = 1'b1;
                wr_addr             = fill[SW-1:0];
                wr_data.st          = SLOT_READY;
                wr_data.prio        = pri_sat;
                wr_data.wake        = '0;
                wr_data.runs        = '0;
                fill_next           = fill + CW'(1);
                result_next.task_id = ID_W'(fill[SW-1:0]);
              end else begin
                result_next.status = STAT_FULL;
              end
            end
            OP_DISPATCH: begin
              done_next = 1'b0;
              // hand the running task back before the sweep starts
              if (run_valid) begin
                wr_en          = 1'b1;
                wr_data.st     = SLOT_READY;
                run_valid_next = 1'b0;
              end
              now_q_next = cmd.now_ms;
              iss_s_next = cur_s_inc;
              cnt_next   = '0;
              state_next = S_SWEEP;
            end
            OP_COMPLETE: begin
              if (run_valid) begin
                wr_en = 1'b1;
                if (cmd.delays) begin
                  wr_data.wake = cmd.now_ms + cmd.delay_ms;
                  wr_data.st   = SLOT_BLOCKED;
                end else begin
                  wr_data.st = SLOT_READY;
                end
                run_valid_next      = 1'b0;
                result_next.task_id = ID_W'(run_slot);
              end else begin
                result_next.status = STAT_BAD;
              end
            end
            default: begin
              result_next.status = STAT_BAD;
            end
          endcase
        end
      end
      S_SWEEP: begin
        iss_s_next = iss_s_inc;
        cur_s_next = cur_s_inc;
        if (cur_s == LAST_SLOT) begin
          cur_p_next = cur_p_dec;
        end
        cnt_next = cnt + NCW'(1);
        if (at_top) begin
          uptime_next    = uptime + (now_q - last_time);
          last_time_next = now_q;
        end
        wr_addr = cur_s;
        wr_data = rec;
        if (grant) begin
          wr_en               = 1'b1;
          wr_data.st          = SLOT_RUNNING;
          wr_data.runs        = rec.runs + TIME_W'(1);
          run_rec_next        = wr_data;
          run_valid_next      = 1'b1;
          run_slot_next       = cur_s;
          done_next           = 1'b1;
          result_next.status  = STAT_OK;
          result_next.task_id = ID_W'(cur_s);
          state_next          = S_IDLE;
        end else begin
          if (wake_wr) begin
            wr_en      = 1'b1;
            wr_data.st = SLOT_READY;
          end
          if (cnt == LAST_POS) begin
            done_next           = 1'b1;
            result_next.status  = STAT_NONE;
            result_next.task_id = '0;
            state_next          = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    result_next.uptime_ms = uptime_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cur_s     <= '0;
      cur_p     <= TOP_PRIO;
      run_valid <= 1'b0;
      fill      <= '0;
      cnt       <= '0;
      uptime    <= '0;
      last_time <= '0;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      cur_s     <= cur_s_next;
      cur_p     <= cur_p_next;
      run_valid <= run_valid_next;
      fill      <= fill_next;
      cnt       <= cnt_next;
      uptime    <= uptime_next;
      last_time <= last_time_next;
      done      <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    iss_s    <= iss_s_next;
    run_slot <= run_slot_next;
    run_rec  <= run_rec_next;
    now_q    <= now_q_next;
    result   <= result_next;
  end

  a_id_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status != STAT_OK)) |-> (result.task_id == '0))
    else $error("task id not zero on a failed transaction");

  a_run_in_table: assert property (@(posedge clk) disable iff (rst)
    run_valid |-> (CW'(run_slot) < fill))
    else $error("running slot beyond filled part of table");

  a_sweep_no_runner: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP) |-> !run_valid)
    else $error("running task not handed back before sweep");

  a_sweep_ends: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SWEEP) && (cnt == LAST_POS)) |=> done)
    else $error("full sweep ended without a result");

endmodule

// ----- tb/ptd_checker.sv -----
// Scoreboard for the priority task dispatcher: tracks the task table and checks each result.
module ptd_checker #(
  parameter int SLOTS  = 8,
  parameter int LEVELS = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  ptd_pkg::cmd_t    cmd,
  input  logic             done,
  input  ptd_pkg::result_t result,
  output int               fail_count,
  output int               pending
);
  import ptd_pkg::*;

  slot_state_t       slot_st   [SLOTS];
  logic [1:0]        slot_pri  [SLOTS];
  logic [TIME_W-1:0] slot_wake [SLOTS];
  int unsigned       cur_pri;
  int unsigned       cur_slot;
  bit                have_running;
  int unsigned       running_idx;
  logic [TIME_W-1:0] uptime_acc;
  logic [TIME_W-1:0] last_now;
  result_t           awaited_results[$];
  int                mismatch_cnt;

  initial begin
    fail_count   = 0;
    pending      = 0;
    mismatch_cnt = 0;
  end

  // Apply one transaction to the shadow table and return the result it should produce.
  function automatic result_t schedule_step(cmd_t c);
    result_t           r;
    logic [1:0]        pri;
    logic [TIME_W-1:0] lag;
    int unsigned       s;
    int unsigned       p;
    r = '0;
    r.status = STAT_BAD;
    case (c.operation)
      OP_ADD: begin
        pri = (c.priority_req >= LEVELS) ? 2'(LEVELS - 1) : c.priority_req;
        r.status = STAT_FULL;
        for (int i = 0; i < SLOTS; i++) begin
          if (r.status == STAT_FULL && slot_st[i] == SLOT_INACTIVE) begin
            slot_st[i]   = SLOT_READY;
            slot_pri[i]  = pri;
            slot_wake[i] = '0;
            r.status     = STAT_OK;
            r.task_id    = ID_W'(i);
          end
        end
      end
      OP_DISPATCH: begin
        // a running task is pushed back to ready before the sweep
        if (have_running) begin
          if (slot_st[running_idx] == SLOT_RUNNING) slot_st[running_idx] = SLOT_READY;
          have_running = 1'b0;
        end
        r.status = STAT_NONE;
        for (int k = 0; k < SLOTS * LEVELS && r.status == STAT_NONE; k++) begin
          s = cur_slot;
          p = cur_pri;
          if (p == LEVELS - 1 && s == 0) begin
            uptime_acc = uptime_acc + (c.now_ms - last_now);
            last_now   = c.now_ms;
          end
          if (cur_slot == SLOTS - 1) begin
            cur_slot = 0;
            cur_pri  = (cur_pri == 0) ? LEVELS - 1 : cur_pri - 1;
          end else begin
            cur_slot++;
          end
          lag = c.now_ms - slot_wake[s];
          if (slot_st[s] == SLOT_BLOCKED && !lag[TIME_W-1]) slot_st[s] = SLOT_READY;
          if (slot_st[s] == SLOT_READY && slot_pri[s] == p) begin
            slot_st[s]   = SLOT_RUNNING;
            have_running = 1'b1;
            running_idx  = s;
            r.status     = STAT_OK;
            r.task_id    = ID_W'(s);
          end
        end
      end
      OP_COMPLETE: begin
        if (have_running && slot_st[running_idx] == SLOT_RUNNING) begin
          if (c.delays) begin
            slot_wake[running_idx] = c.now_ms + c.delay_ms;
            slot_st[running_idx]   = SLOT_BLOCKED;
          end else begin
            slot_st[running_idx] = SLOT_READY;
          end
          have_running = 1'b0;
          r.status     = STAT_OK;
          r.task_id    = ID_W'(running_idx);
        end
      end
      default: ;
    endcase
    r.uptime_ms = uptime_acc;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t exp_res;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_st[i]   = SLOT_INACTIVE;
        slot_pri[i]  = 2'd1;
        slot_wake[i] = '0;
      end
      cur_pri      = LEVELS - 1;
      cur_slot     = 0;
      have_running = 1'b0;
      running_idx  = 0;
      uptime_acc   = '0;
      last_now     = '0;
      awaited_results.delete();
    end else begin
      // check the strobed result before queueing this edge's transaction
      if (done) begin
        if (awaited_results.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected result: status %0d id %0d uptime %0d",
                     result.status, result.task_id, result.uptime_ms);
        end else begin
          exp_res = awaited_results.pop_front();
          if (result.status !== exp_res.status || result.task_id !== exp_res.task_id ||
              result.uptime_ms !== exp_res.uptime_ms) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("mismatch: expected status %0d id %0d uptime %0d, got %0d %0d %0d",
                       exp_res.status, exp_res.task_id, exp_res.uptime_ms,
                       result.status, result.task_id, result.uptime_ms);
          end
        end
      end
      if (start && !busy) awaited_results.push_back(schedule_step(cmd));
    end
    fail_count <= mismatch_cnt;
    pending    <= awaited_results.size();
  end

endmodule

// ----- tb/tb.sv -----
// Top-level bench: drives dispatcher transactions and gives the verdict.
module tb;
  import ptd_pkg::*;

  localparam logic [1:0] OP_UNKNOWN   = 2'd3;
  localparam int         ITEM_TARGET  = 1150;
  localparam int         STALL_LIMIT  = 1000;
  localparam int         DRAIN_CYCLES = 40;

  logic        clk   = 1'b0;
  logic        rst   = 1'b1;
  logic        start = 1'b0;
  cmd_t        cmd   = '0;
  logic        busy;
  logic        done;
  result_t     result;
  int          fail_count;
  int          pending;
  int          items_sent  = 0;
  int          burst_left  = 0;
  int          stall_cnt   = 0;
  int          pick;
  logic [31:0] clock_ms    = '0;

  always #5 clk = ~clk;

  priority_task_dispatcher i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  ptd_checker i_check (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .done       (done),
    .result     (result),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cnt <= 0;
    end else if (stall_cnt == STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  function automatic cmd_t make_cmd(logic [1:0] op, logic [1:0] pri, logic [31:0] now,
                                    logic [31:0] delay, logic sleep);
    cmd_t c;
    c.operation    = op;
    c.priority_req = pri;
    c.now_ms       = now;
    c.delay_ms     = delay;
    c.delays       = sleep;
    return c;
  endfunction

  function automatic logic [31:0] tick();
    clock_ms = clock_ms + $urandom_range(15, 0);
    return clock_ms;
  endfunction

  // mostly short sleeps so blocked tasks wake again; now and then any length
  function automatic logic [31:0] sleep_len();
    return ($urandom_range(19, 0) == 0) ? $urandom : $urandom_range(60, 0);
  endfunction

  task automatic issue(cmd_t c);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(9, 0) == 0) ? 150 : $urandom_range(20, 1);
      if ($urandom_range(3, 0) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(40, 1)) @(posedge clk);
      end
    end
    burst_left--;
    cmd   <= c;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    issue(make_cmd(OP_DISPATCH, 2'd0, 32'd0, 32'd0, 1'b0));
    issue(make_cmd(OP_COMPLETE, 2'd0, 32'd0, 32'd0, 1'b0));
    issue(make_cmd(OP_UNKNOWN, 2'd3, '1, '1, 1'b1));
    issue(make_cmd(OP_ADD, 2'd3, 32'd5, 32'd0, 1'b0));
    issue(make_cmd(OP_ADD, 2'd0, 32'd6, 32'd0, 1'b0));
    issue(make_cmd(OP_ADD, 2'd1, 32'd7, 32'd0, 1'b0));
    issue(make_cmd(OP_ADD, 2'd2, 32'd8, 32'd0, 1'b0));
    issue(make_cmd(OP_DISPATCH, 2'd0, 32'd100, 32'd0, 1'b0));
    // dispatch again while a task still runs
    issue(make_cmd(OP_DISPATCH, 2'd0, 32'd110, 32'd0, 1'b0));
    // sleep length wraps the wake time just behind now
    issue(make_cmd(OP_COMPLETE, 2'd0, 32'd120, '1, 1'b1));
    issue(make_cmd(OP_DISPATCH, 2'd0, 32'd130, 32'd0, 1'b0));
    issue(make_cmd(OP_COMPLETE, 2'd0, 32'd140, 32'd0, 1'b1));
    issue(make_cmd(OP_COMPLETE, 2'd0, 32'd141, 32'd0, 1'b0));
    issue(make_cmd(OP_DISPATCH, 2'd0, 32'hFFFF_FFF0, 32'd0, 1'b0));
    issue(make_cmd(OP_COMPLETE, 2'd0, 32'hFFFF_FFF0, 32'h7FFF_FFFF, 1'b1));
    // time wraps past zero
    issue(make_cmd(OP_DISPATCH, 2'd0, 32'h0000_0010, 32'd0, 1'b0));
    issue(make_cmd(OP_COMPLETE, 2'd0, 32'h0000_0012, 32'd0, 1'b0));
    issue(make_cmd(OP_ADD, 2'd3, 32'h14, 32'd0, 1'b0));
    issue(make_cmd(OP_ADD, 2'd2, 32'h15, 32'd0, 1'b0));
    issue(make_cmd(OP_ADD, 2'd1, 32'h16, 32'd0, 1'b0));
    issue(make_cmd(OP_ADD, 2'd0, 32'h17, 32'd0, 1'b0));
    issue(make_cmd(OP_ADD, 2'd1, 32'h18, 32'd0, 1'b0));
    clock_ms = 32'h20;

    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(99, 0);
      if (pick < 70) begin
        issue(make_cmd(OP_DISPATCH, 2'($urandom_range(3, 0)), tick(), $urandom,
                       1'($urandom_range(1, 0))));
        if ($urandom_range(9, 0) != 0)
          issue(make_cmd(OP_COMPLETE, 2'($urandom_range(3, 0)), tick(), sleep_len(),
                         $urandom_range(4, 0) < 3));
      end else if (pick < 80) begin
        issue(make_cmd(OP_DISPATCH, 2'($urandom_range(3, 0)), tick(), $urandom, 1'b0));
      end else if (pick < 86) begin
        issue(make_cmd(OP_COMPLETE, 2'($urandom_range(3, 0)), tick(), sleep_len(),
                       1'($urandom_range(1, 0))));
      end else if (pick < 90) begin
        issue(make_cmd(OP_ADD, 2'($urandom_range(3, 0)), tick(), $urandom,
                       1'($urandom_range(1, 0))));
      end else if (pick < 93) begin
        issue(make_cmd(OP_UNKNOWN, 2'($urandom_range(3, 0)), $urandom, $urandom,
                       1'($urandom_range(1, 0))));
      end else begin
        // jump time anywhere to wake long sleepers or leave them asleep
        clock_ms = $urandom;
        issue(make_cmd(OP_DISPATCH, 2'($urandom_range(3, 0)), clock_ms, $urandom,
                       1'($urandom_range(1, 0))));
      end
    end

    start <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- priority_task_dispatcher.f -----
rtl/ptd_pkg.sv
rtl/ptd_table.sv
rtl/priority_task_dispatcher.sv
tb/ptd_checker.sv
tb/tb.sv
